// ===== rtl/sky_dome_texcoord_generator_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SKY_DOME_TEXCOORD_GENERATOR_MACROS_SVH
`define SKY_DOME_TEXCOORD_GENERATOR_MACROS_SVH

// expr must hold at every clock edge outside reset
`define SDT_ASSERT_HOLD(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sdt check failed: lbl");

// ante at an edge implies the sequence cons from that edge
`define SDT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("sdt check failed: lbl");

`endif

// ===== rtl/sdt_pkg.sv =====
// Types and constants of the sky dome texcoord generator.
`default_nettype none
package sdt_pkg;

    typedef struct packed {
        logic signed [23:0] vert_x;
        logic signed [23:0] vert_y;
        logic signed [23:0] vert_z;
    } in_item_t;

    typedef struct packed {
        logic signed [19:0] tex_s;
        logic signed [19:0] tex_t;
        logic               degenerate;
    } out_item_t;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_VIEW_X    = 3'd0;
    localparam logic [2:0] REG_VIEW_Y    = 3'd1;
    localparam logic [2:0] REG_VIEW_Z    = 3'd2;
    localparam logic [2:0] REG_TIME_NOW  = 3'd3;
    localparam logic [2:0] REG_LAYER_SEL = 3'd4;

    localparam int SKY_SCALE    = 378;   // 6 * 63
    localparam int SHIFT_SOLID  = 3;     // speed 8
    localparam int SHIFT_ALPHA  = 4;     // speed 16
    localparam int TEX_DIV_SH   = 7;     // divide by 128
    localparam int SQ_STEPS     = 30;    // root bits
    localparam int DIV_STEPS    = 25;    // quotient bits
    localparam int RED_W        = 38;    // scroll reduction width
    localparam int LATENCY      = SQ_STEPS + DIV_STEPS + 5;

    localparam logic signed [19:0] OUT_MAX = 20'sh7FFFF;
    localparam logic signed [19:0] OUT_MIN = 20'sh80000;

    // one square-root step
    typedef struct packed {
        logic [59:0]      rad;
        logic [60:0]      rt;
        logic [24:0]      ax;
        logic [24:0]      ay;
        logic             sgn_x;
        logic             sgn_y;
        logic             degen;
        logic [RED_W-1:0] red;
    } sq_stage_t;

    // one divider step
    typedef struct packed {
        logic [54:0]      rem_x;
        logic [54:0]      rem_y;
        logic [24:0]      q_x;
        logic [24:0]      q_y;
        logic [29:0]      len;
        logic             sgn_x;
        logic             sgn_y;
        logic             degen;
        logic [RED_W-1:0] red;
    } dv_stage_t;

endpackage
`default_nettype wire

// ===== rtl/sky_dome_texcoord_generator.sv =====
// Top level: pipelined sky dome texture coordinate generator.
`default_nettype none
// Usage
//   Input: one sky-polygon vertex per item on vert, taken at a rising edge with
//   start high and busy low. busy never rises, so an item may enter every cycle.
//   Output: done pulses for one cycle with tex holding s, t and the degenerate
//   flag. Results come in input order; the receiver cannot hold them off and the
//   pipeline never stalls.
//   Throughput: one item per cycle.
//   The depth is set by the restoring square root (30 stages, one root bit each)
//   and the restoring divider (25 stages, one quotient bit each, both axes side
//   by side), plus entry, square, sum, scale and output stages.
//   The scroll offset is reduced modulo SCROLL_WRAP << 16 by shift-and-subtract
//   steps riding along the square-root stages.
//   Config: APB-style registers at 4*index; the user writes only while idle, unchecked.
//   Reset: clears the registers and all valid bits; no item is in flight after.
module sky_dome_texcoord_generator #(
    parameter int SCROLL_WRAP = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sdt_pkg::in_item_t vert,
    output logic                   done,
    output sdt_pkg::out_item_t     tex,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int SCR_W     = $clog2(SCROLL_WRAP) + 16;
    // steps to bring time*speed (< 2^36) below the wrap
    localparam int RED_STEPS = 22 - $clog2(SCROLL_WRAP);
    localparam int SUM_W     = ((SCR_W > 25) ? SCR_W : 25) + 2;

    // ---------------- configuration ----------------
    logic [23:0] view_x_reg, view_y_reg, view_z_reg;
    logic [31:0] time_now_reg;
    logic        layer_sel_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_x_reg    <= '0;
            view_y_reg    <= '0;
            view_z_reg    <= '0;
            time_now_reg  <= '0;
            layer_sel_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                sdt_pkg::REG_VIEW_X:    view_x_reg    <= pwdata[23:0];
                sdt_pkg::REG_VIEW_Y:    view_y_reg    <= pwdata[23:0];
                sdt_pkg::REG_VIEW_Z:    view_z_reg    <= pwdata[23:0];
                sdt_pkg::REG_TIME_NOW:  time_now_reg  <= pwdata;
                sdt_pkg::REG_LAYER_SEL: layer_sel_reg <= pwdata[0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sdt_pkg::REG_VIEW_X:    prdata = {8'b0, view_x_reg};
            sdt_pkg::REG_VIEW_Y:    prdata = {8'b0, view_y_reg};
            sdt_pkg::REG_VIEW_Z:    prdata = {8'b0, view_z_reg};
            sdt_pkg::REG_TIME_NOW:  prdata = time_now_reg;
            sdt_pkg::REG_LAYER_SEL: prdata = {31'b0, layer_sel_reg};
            default:                prdata = '0;
        endcase
    end

    // ---------------- stage 1: differences ----------------
    logic               s1_valid_reg;
    logic signed [24:0] s1_dx_reg, s1_dy_reg;
    logic signed [26:0] s1_dz3_reg;
    logic [35:0]        s1_t_reg;
    logic signed [24:0] dz_next;

    assign dz_next = 25'(vert.vert_z) - 25'($signed(view_z_reg));

    always_ff @(posedge clk)
    begin
        s1_dx_reg  <= 25'(vert.vert_x) - 25'($signed(view_x_reg));
        s1_dy_reg  <= 25'(vert.vert_y) - 25'($signed(view_y_reg));
        // 3*dz as dz + 2*dz
        s1_dz3_reg <= 27'(dz_next) + (27'(dz_next) <<< 1);
        s1_t_reg   <= layer_sel_reg ? (36'(time_now_reg) << sdt_pkg::SHIFT_ALPHA)
                                    : (36'(time_now_reg) << sdt_pkg::SHIFT_SOLID);
    end

    // ---------------- stage 2: squares ----------------
    logic        s2_valid_reg;
    logic [49:0] s2_sqx_reg, s2_sqy_reg;
    logic [51:0] s2_sqz_reg;
    logic [24:0] s2_ax_reg, s2_ay_reg;
    logic        s2_sx_reg, s2_sy_reg;
    logic [35:0] s2_t_reg;
    logic [24:0] ax, ay;
    logic [25:0] az;

    assign ax = s1_dx_reg[24] ? 25'(-s1_dx_reg) : 25'(s1_dx_reg);
    assign ay = s1_dy_reg[24] ? 25'(-s1_dy_reg) : 25'(s1_dy_reg);
    assign az = s1_dz3_reg[26] ? 26'(-s1_dz3_reg) : 26'(s1_dz3_reg);

    always_ff @(posedge clk)
    begin
        s2_sqx_reg <= 50'(ax) * 50'(ax);
        s2_sqy_reg <= 50'(ay) * 50'(ay);
        s2_sqz_reg <= 52'(az) * 52'(az);
        s2_ax_reg  <= ax;
        s2_ay_reg  <= ay;
        s2_sx_reg  <= s1_dx_reg[24];
        s2_sy_reg  <= s1_dy_reg[24];
        s2_t_reg   <= s1_t_reg;
    end

    // ---------------- stage 3: sum of squares, root setup ----------------
    sdt_pkg::sq_stage_t sq_reg [0:sdt_pkg::SQ_STEPS];
    logic [sdt_pkg::SQ_STEPS:0] sq_valid_reg;
    logic [51:0] sumsq;

    assign sumsq = 52'(s2_sqx_reg) + 52'(s2_sqy_reg) + s2_sqz_reg;

    always_ff @(posedge clk)
    begin
        sq_reg[0].rad   <= {sumsq, 8'b0};
        sq_reg[0].rt    <= '0;
        sq_reg[0].ax    <= s2_ax_reg;
        sq_reg[0].ay    <= s2_ay_reg;
        sq_reg[0].sgn_x <= s2_sx_reg;
        sq_reg[0].sgn_y <= s2_sy_reg;
        sq_reg[0].degen <= (sumsq == '0);
        sq_reg[0].red   <= sdt_pkg::RED_W'(s2_t_reg);
    end

    // ---------------- square root, one bit per stage ----------------
    for (genvar j = 0; j < sdt_pkg::SQ_STEPS; j++)
    begin : g_sq
        localparam logic [60:0] BIT = 61'(1) << (58 - 2 * j);
        sdt_pkg::sq_stage_t nxt;
        logic [60:0] trial;

        assign trial = sq_reg[j].rt + BIT;

        always_comb
        begin
            nxt = sq_reg[j];
            if ({1'b0, sq_reg[j].rad} >= trial)
            begin
                nxt.rad = sq_reg[j].rad - trial[59:0];
                nxt.rt  = (sq_reg[j].rt >> 1) + BIT;
            end
            else
            begin
                nxt.rt = sq_reg[j].rt >> 1;
            end
            // scroll wrap, largest multiple first
            if (j < RED_STEPS)
            begin
                if (sq_reg[j].red >= (sdt_pkg::RED_W'(SCROLL_WRAP) << (16 + RED_STEPS - 1 - j)))
                begin
                    nxt.red = sq_reg[j].red
                            - (sdt_pkg::RED_W'(SCROLL_WRAP) << (16 + RED_STEPS - 1 - j));
                end
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[j + 1] <= nxt;
        end
    end

    // ---------------- scale stage: |d| * 378 << 20 ----------------
    sdt_pkg::dv_stage_t dv_reg [0:sdt_pkg::DIV_STEPS];
    logic [sdt_pkg::DIV_STEPS:0] dv_valid_reg;
    logic [33:0] prod_x, prod_y;

    assign prod_x = 34'(sq_reg[sdt_pkg::SQ_STEPS].ax) * 34'(sdt_pkg::SKY_SCALE);
    assign prod_y = 34'(sq_reg[sdt_pkg::SQ_STEPS].ay) * 34'(sdt_pkg::SKY_SCALE);

    always_ff @(posedge clk)
    begin
        dv_reg[0].rem_x <= {1'b0, prod_x, 20'b0};
        dv_reg[0].rem_y <= {1'b0, prod_y, 20'b0};
        dv_reg[0].q_x   <= '0;
        dv_reg[0].q_y   <= '0;
        dv_reg[0].len   <= sq_reg[sdt_pkg::SQ_STEPS].rt[29:0];
        dv_reg[0].sgn_x <= sq_reg[sdt_pkg::SQ_STEPS].sgn_x;
        dv_reg[0].sgn_y <= sq_reg[sdt_pkg::SQ_STEPS].sgn_y;
        dv_reg[0].degen <= sq_reg[sdt_pkg::SQ_STEPS].degen;
        dv_reg[0].red   <= sq_reg[sdt_pkg::SQ_STEPS].red;
    end

    // ---------------- divider, one quotient bit per stage ----------------
    for (genvar j = 0; j < sdt_pkg::DIV_STEPS; j++)
    begin : g_dv
        localparam int K = sdt_pkg::DIV_STEPS - 1 - j;
        sdt_pkg::dv_stage_t nxt;
        logic [54:0] dsr;

        assign dsr = 55'(dv_reg[j].len) << K;

        always_comb
        begin
            nxt = dv_reg[j];
            if (dv_reg[j].rem_x >= dsr)
            begin
                nxt.rem_x  = dv_reg[j].rem_x - dsr;
                nxt.q_x[K] = 1'b1;
            end
            if (dv_reg[j].rem_y >= dsr)
            begin
                nxt.rem_y  = dv_reg[j].rem_y - dsr;
                nxt.q_y[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[j + 1] <= nxt;
        end
    end

    // ---------------- output: offset, floor /128, saturate ----------------
    sdt_pkg::dv_stage_t fin;
    logic signed [SUM_W-1:0] scroll, off_x, off_y, sum_x, sum_y, shr_x, shr_y;
    sdt_pkg::out_item_t out_next, out_reg;
    logic done_reg;

    assign fin    = dv_reg[sdt_pkg::DIV_STEPS];
    assign scroll = SUM_W'($signed({1'b0, fin.red[SCR_W-1:0]}));

    always_comb
    begin
        off_x = fin.sgn_x ? -SUM_W'($signed({1'b0, fin.q_x})) : SUM_W'($signed({1'b0, fin.q_x}));
        off_y = fin.sgn_y ? -SUM_W'($signed({1'b0, fin.q_y})) : SUM_W'($signed({1'b0, fin.q_y}));
        if (fin.degen)
        begin
            off_x = '0;
            off_y = '0;
        end
        sum_x = scroll + off_x;
        sum_y = scroll + off_y;
        shr_x = sum_x >>> sdt_pkg::TEX_DIV_SH;
        shr_y = sum_y >>> sdt_pkg::TEX_DIV_SH;
        if (shr_x > SUM_W'(sdt_pkg::OUT_MAX))
            out_next.tex_s = sdt_pkg::OUT_MAX;
        else if (shr_x < SUM_W'(sdt_pkg::OUT_MIN))
            out_next.tex_s = sdt_pkg::OUT_MIN;
        else
            out_next.tex_s = shr_x[19:0];
        if (shr_y > SUM_W'(sdt_pkg::OUT_MAX))
            out_next.tex_t = sdt_pkg::OUT_MAX;
        else if (shr_y < SUM_W'(sdt_pkg::OUT_MIN))
            out_next.tex_t = sdt_pkg::OUT_MIN;
        else
            out_next.tex_t = shr_y[19:0];
        out_next.degenerate = fin.degen;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // valid bits travel alongside the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sq_valid_reg <= '0;
            dv_valid_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            sq_valid_reg <= {sq_valid_reg[sdt_pkg::SQ_STEPS-1:0], s2_valid_reg};
            dv_valid_reg <= {dv_valid_reg[sdt_pkg::DIV_STEPS-1:0],
                             sq_valid_reg[sdt_pkg::SQ_STEPS]};
            done_reg     <= dv_valid_reg[sdt_pkg::DIV_STEPS];
        end
    end

    assign done = done_reg;
    assign tex  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/sdt_checker.sv =====
// Port-level checker for the sky dome texcoord generator, with its bind.
`default_nettype none
`include "sky_dome_texcoord_generator_macros.svh"
module sdt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire sdt_pkg::out_item_t tex,
    input wire logic               pready
);

    `SDT_ASSERT_IMPL(a_result_follows, start && !busy, ##(sdt_pkg::LATENCY) done)
    `SDT_ASSERT_IMPL(a_result_has_item, done, $past(start && !busy, sdt_pkg::LATENCY))
    `SDT_ASSERT_IMPL(a_degen_same, done && tex.degenerate, tex.tex_s == tex.tex_t)
    `SDT_ASSERT_HOLD(a_never_busy, !busy && pready)

endmodule

bind sky_dome_texcoord_generator sdt_checker u_sdt_checker (.*);
`default_nettype wire
